FILE: rtl/vde_pkg.sv
// Shared constants, codes and state type of the vector distance engine.
package vde_pkg;

	localparam int ELEM_W   = 16;
	localparam int LEN_W    = 11;
	localparam int DIST_W   = 48;
	localparam int MAX_LEN  = 1024;
	localparam int SQD_W    = 43;
	localparam int DOT_W    = 42;
	localparam int SQ_W     = 41;
	localparam int MUL_W    = 30;
	localparam int ROOT_W   = 30;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int DEN_W    = 58;
	localparam int FRAC_W   = 32;
	localparam int NUM_W    = DOT_W + FRAC_W;

	typedef enum logic [1:0] {
		MET_EUCLID = 2'd0,
		MET_INNER  = 2'd1,
		MET_NEG    = 2'd2,
		MET_COSINE = 2'd3
	} metric_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_ZERO = 2'd1,
		STAT_SAT  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MD,
		ST_MA,
		ST_MB,
		ST_MP,
		ST_ACCP,
		ST_FIN,
		ST_SQE,
		ST_SQA,
		ST_SQB,
		ST_MULM,
		ST_DIVS,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/vde_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module vde_isqrt
	import vde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  x,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  x_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0]  rem_n;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_n = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign fits  = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/vde_div.sv
// Restoring divider, one quotient bit per cycle, keeps the low result bits.
module vde_div
	import vde_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [DIST_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    rem_q;
	logic [DIST_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    rem_n;
	logic              fits;

	assign rem_n = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign fits  = rem_n >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_n - {1'b0, den_q} : rem_n;
			quo_q <= {quo_q[DIST_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/vector_distance_engine.sv
// Vector distance engine top level: sequencer, accumulators and output register.
//
// Element pairs (signed Q8.8) arrive one request at a time. Each taken request
// keeps the input stalled while the sequencer steps through MD, MA, MB, MP and
// ACCP, so a new pair is accepted only after the previous one is folded in. The
// single shared 30x30 multiplier forms the squared difference, both squares and
// the product, with a saturating add behind it. On the pair marked last the result
// is formed. Inner product metrics and cosine with a zero magnitude go from FIN
// straight to OUT. Euclidean distance adds the bit-serial square root. Cosine
// distance adds two roots, one multiply and a restoring divide. Input stall stays
// high for the whole of this work, and for as long as the previous result still
// waits in the output register. Once a result is in the output register, a new
// vector may start while it waits to be taken. Pairs beyond MAX_LEN are dropped
// and flag status 2; cosine with a zero magnitude returns 0 with status 1.
module vector_distance_engine
	import vde_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ELEM_W-1:0] elem_a,
	input  logic signed [ELEM_W-1:0] elem_b,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DIST_W-1:0] distance,
	output logic [1:0]               status,
	output logic [LEN_W-1:0]         length
);

	state_t state_q, state_d;

	metric_t                  metric_q;
	logic signed [ELEM_W-1:0] a_q, b_q;
	logic                     last_q;
	logic [SQD_W-1:0]         sqd_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic [SQ_W-1:0]          sa_q, sb_q;
	logic [LEN_W-1:0]         cnt_q;
	logic                     sat_q;
	logic signed [2*MUL_W-1:0] prod_q;
	logic [ROOT_W-1:0]        ma_q, mb_q;
	logic [DIST_W-1:0]        res_dist_q;
	status_t                  res_status_q;
	logic                     out_valid_q;
	logic [DIST_W-1:0]        out_dist_q;
	status_t                  out_status_q;
	logic [LEN_W-1:0]         out_len_q;

	logic                     accept;
	logic                     full;
	logic                     zero_mag;
	logic                     out_free;
	logic signed [ELEM_W:0]   diff;
	logic signed [MUL_W-1:0]  mul_x, mul_y;
	logic                     sq_start, sq_done;
	logic [RAD_W-1:0]         sq_x;
	logic [ROOT_W-1:0]        sq_root;
	logic                     div_start, div_done;
	logic [DOT_W-1:0]         dot_abs;
	logic [DIST_W-1:0]        quo;
	logic [SQD_W:0]           sqd_sum;
	logic [SQ_W:0]            sa_sum, sb_sum;
	logic signed [DOT_W:0]    dot_sum;

	assign accept   = in_valid && !in_stall;
	assign full     = cnt_q >= LEN_W'(MAX_LEN);
	assign zero_mag = (sa_q == '0) || (sb_q == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign diff     = $signed({a_q[ELEM_W-1], a_q}) - $signed({b_q[ELEM_W-1], b_q});
	assign dot_abs  = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);

	// saturating adds: unsigned limits are all ones, so overflow is the carry
	assign sqd_sum = {1'b0, sqd_q} + (SQD_W+1)'(prod_q[32:0]);
	assign sa_sum  = {1'b0, sa_q} + (SQ_W+1)'(prod_q[30:0]);
	assign sb_sum  = {1'b0, sb_q} + (SQ_W+1)'(prod_q[30:0]);
	assign dot_sum = (DOT_W+1)'(dot_q) + (DOT_W+1)'($signed(prod_q[33:0]));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!full)
						state_d = ST_MD;
					else if (last)
						state_d = ST_FIN;
				end
			end
			ST_MD:   state_d = ST_MA;
			ST_MA:   state_d = ST_MB;
			ST_MB:   state_d = ST_MP;
			ST_MP:   state_d = ST_ACCP;
			ST_ACCP: state_d = last_q ? ST_FIN : ST_IDLE;
			ST_FIN: begin
				unique case (metric_q)
					MET_EUCLID:         state_d = ST_SQE;
					MET_INNER, MET_NEG: state_d = ST_OUT;
					MET_COSINE:         state_d = zero_mag ? ST_OUT : ST_SQA;
					default:            state_d = ST_OUT;
				endcase
			end
			ST_SQE:  if (sq_done) state_d = ST_OUT;
			ST_SQA:  if (sq_done) state_d = ST_SQB;
			ST_SQB:  if (sq_done) state_d = ST_MULM;
			ST_MULM: state_d = ST_DIVS;
			ST_DIVS: state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = state_q != ST_IDLE;
		sq_start  = 1'b0;
		sq_x      = {1'b0, sqd_q, 16'b0};
		div_start = state_q == ST_DIVS;
		mul_x     = MUL_W'(diff);
		mul_y     = MUL_W'(diff);
		unique case (state_q)
			ST_FIN: begin
				if (metric_q == MET_EUCLID) begin
					sq_start = 1'b1;
				end else if (metric_q == MET_COSINE && !zero_mag) begin
					sq_start = 1'b1;
					sq_x     = {3'b0, sa_q, 16'b0};
				end
			end
			ST_SQA: begin
				sq_start = sq_done;
				sq_x     = {3'b0, sb_q, 16'b0};
			end
			ST_MA: begin
				mul_x = MUL_W'(a_q);
				mul_y = MUL_W'(a_q);
			end
			ST_MB: begin
				mul_x = MUL_W'(b_q);
				mul_y = MUL_W'(b_q);
			end
			ST_MP: begin
				mul_x = MUL_W'(a_q);
				mul_y = MUL_W'(b_q);
			end
			ST_SQB: begin
				mul_x = $signed(ma_q);
				mul_y = $signed(mb_q);
			end
			ST_MULM: begin
				mul_x = $signed(ma_q);
				mul_y = $signed(mb_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			metric_q    <= MET_EUCLID;
			sqd_q       <= '0;
			dot_q       <= '0;
			sa_q        <= '0;
			sb_q        <= '0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				metric_q <= metric_t'(cfg_wr_data);
			if (accept) begin
				if (full)
					sat_q <= 1'b1;
				else
					cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_MA: begin
					if (sqd_sum[SQD_W]) begin
						sqd_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sqd_q <= sqd_sum[SQD_W-1:0];
					end
				end
				ST_MB: begin
					if (sa_sum[SQ_W]) begin
						sa_q  <= '1;
						sat_q <= 1'b1;
					end else begin
						sa_q <= sa_sum[SQ_W-1:0];
					end
				end
				ST_MP: begin
					if (sb_sum[SQ_W]) begin
						sb_q  <= '1;
						sat_q <= 1'b1;
					end else begin
						sb_q <= sb_sum[SQ_W-1:0];
					end
				end
				ST_ACCP: begin
					if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
						dot_q <= dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
							: {1'b0, {(DOT_W-1){1'b1}}};
						sat_q <= 1'b1;
					end else begin
						dot_q <= dot_sum[DOT_W-1:0];
					end
				end
				ST_OUT: begin
					if (out_free) begin
						sqd_q <= '0;
						dot_q <= '0;
						sa_q  <= '0;
						sb_q  <= '0;
						cnt_q <= '0;
						sat_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= elem_a;
			b_q    <= elem_b;
			last_q <= last;
		end
		prod_q <= mul_x * mul_y;
		if (state_q == ST_FIN) begin
			res_status_q <= sat_q ? STAT_SAT : STAT_OK;
			if (metric_q == MET_INNER)
				res_dist_q <= DIST_W'(dot_q);
			else if (metric_q == MET_NEG)
				res_dist_q <= -DIST_W'(dot_q);
			else if (metric_q == MET_COSINE && zero_mag) begin
				res_dist_q   <= '0;
				res_status_q <= STAT_ZERO;
			end
		end
		if (state_q == ST_SQE && sq_done)
			res_dist_q <= DIST_W'(sq_root);
		if (state_q == ST_SQA && sq_done)
			ma_q <= sq_root;
		if (state_q == ST_SQB && sq_done)
			mb_q <= sq_root;
		if (state_q == ST_DIV && div_done)
			res_dist_q <= dot_q[DOT_W-1] ? DIST_W'(65536) + quo : DIST_W'(65536) - quo;
		if (state_q == ST_OUT && out_free) begin
			out_dist_q   <= res_dist_q;
			out_status_q <= res_status_q;
			out_len_q    <= cnt_q;
		end
	end

	vde_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.done   (sq_done),
		.root   (sq_root)
	);

	vde_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({dot_abs, {FRAC_W{1'b0}}}),
		.den    (prod_q[DEN_W-1:0]),
		.done   (div_done),
		.quo    (quo)
	);

	assign out_valid = out_valid_q;
	assign distance  = $signed(out_dist_q);
	assign status    = out_status_q;
	assign length    = out_len_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LEN_W'(MAX_LEN))
		else $error("pair count beyond maximum length");

	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVS |-> prod_q[DEN_W-1:0] != '0)
		else $error("divide started with zero magnitude product");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STAT_ZERO) |-> out_dist_q == '0)
		else $error("zero magnitude status with nonzero distance");

	a_out_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (cnt_q == '0 && !sat_q))
		else $error("accumulators not cleared after result");

endmodule

FILE: tb/sv/vde_checker.sv
// Checker for the vector distance engine: watches both channels, predicts results, compares.
module vde_checker
	import vde_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_wr_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic signed [ELEM_W-1:0] elem_a,
	input  logic signed [ELEM_W-1:0] elem_b,
	input  logic                     last,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DIST_W-1:0] distance,
	input  logic [1:0]               status,
	input  logic [LEN_W-1:0]         length,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] SQD_MAX = (64'd1 << SQD_W) - 64'd1;
	localparam logic [63:0] SQ_MAX  = (64'd1 << SQ_W) - 64'd1;
	localparam longint DOT_MAX = (64'sd1 <<< (DOT_W - 1)) - 64'sd1;
	localparam longint DOT_MIN = -(64'sd1 <<< (DOT_W - 1));

	typedef struct {
		logic signed [DIST_W-1:0] distance;
		logic [1:0]               status;
		logic [LEN_W-1:0]         length;
	} vde_result_t;

	vde_result_t result_q[$];

	metric_t     cur_metric;
	logic [63:0] sqd_acc, sqa_acc, sqb_acc;
	longint      dot_acc;
	int          pairs;
	bit          sat_seen;

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x = x - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] frac_ratio(logic [63:0] n, logic [63:0] d);
		logic [63:0] q, r;
		q = n / d;
		r = n % d;
		for (int i = 0; i < FRAC_W; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] term,
			logic [63:0] lim, ref bit flag);
		if (acc > lim || term > lim - acc) begin
			flag = 1;
			return lim;
		end
		return acc + term;
	endfunction

	// Fold one pair into the sums; on a last pair push the expected result.
	task automatic predict_pair(longint a, longint b, logic lst);
		longint d, p, s, dist_v;
		logic [63:0] ad, ua, ub, ma, mb, n, q;
		vde_result_t res;
		if (pairs >= MAX_LEN) begin
			sat_seen = 1;
		end else begin
			d = a - b;
			ad = d < 0 ? -d : d;
			ua = a < 0 ? -a : a;
			ub = b < 0 ? -b : b;
			p = a * b;
			sqd_acc = sat_add(sqd_acc, ad * ad, SQD_MAX, sat_seen);
			sqa_acc = sat_add(sqa_acc, ua * ua, SQ_MAX, sat_seen);
			sqb_acc = sat_add(sqb_acc, ub * ub, SQ_MAX, sat_seen);
			s = dot_acc + p;
			if (s > DOT_MAX) begin
				s = DOT_MAX;
				sat_seen = 1;
			end else if (s < DOT_MIN) begin
				s = DOT_MIN;
				sat_seen = 1;
			end
			dot_acc = s;
			pairs++;
		end
		if (!lst) return;
		res.status = sat_seen ? STAT_SAT : STAT_OK;
		dist_v = 0;
		case (cur_metric)
			MET_EUCLID: dist_v = longint'(int_sqrt(sqd_acc << 16));
			MET_INNER:  dist_v = dot_acc;
			MET_NEG:    dist_v = -dot_acc;
			default: begin
				if (sqa_acc == 0 || sqb_acc == 0) begin
					dist_v = 0;
					res.status = STAT_ZERO;
				end else begin
					ma = int_sqrt(sqa_acc << 16);
					mb = int_sqrt(sqb_acc << 16);
					n = dot_acc < 0 ? -dot_acc : dot_acc;
					q = frac_ratio(n, ma * mb);
					dist_v = dot_acc < 0 ? 65536 + longint'(q) : 65536 - longint'(q);
				end
			end
		endcase
		res.distance = dist_v[DIST_W-1:0];
		res.length = pairs[LEN_W-1:0];
		result_q.push_back(res);
		sqd_acc = 0;
		sqa_acc = 0;
		sqb_acc = 0;
		dot_acc = 0;
		pairs = 0;
		sat_seen = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		vde_result_t want;
		if (!arst_n) begin
			cur_metric <= MET_EUCLID;
			sqd_acc = 0;
			sqa_acc = 0;
			sqb_acc = 0;
			dot_acc = 0;
			pairs = 0;
			sat_seen = 0;
			result_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				cur_metric <= metric_t'(cfg_wr_data);
			if (in_valid && !in_stall)
				predict_pair(longint'(elem_a), longint'(elem_b), last);
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: distance %0d status %0d length %0d",
						distance, status, length);
					fail_count <= fail_count + 1;
				end else begin
					want = result_q.pop_front();
					if (distance !== want.distance || status !== want.status ||
							length !== want.length)
						fail_count <= fail_count + 1;
					if (distance !== want.distance)
						$error("distance: expected %0d actual %0d", want.distance, distance);
					if (status !== want.status)
						$error("status: expected %0d actual %0d", want.status, status);
					if (length !== want.length)
						$error("length: expected %0d actual %0d", want.length, length);
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
// Top of the vector distance engine testbench: clock, reset, stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vde_pkg::*;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [1:0]               cfg_wr_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DIST_W-1:0] distance;
	logic [1:0]               status;
	logic [LEN_W-1:0]         length;
	int                       fail_count;
	int                       pending;
	bit                       idle_on;

	vector_distance_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_a(elem_a), .elem_b(elem_b), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .status(status), .length(length)
	);

	vde_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_a(elem_a), .elem_b(elem_b), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.distance(distance), .status(status), .length(length),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom % 100 < 25);
	end

	// Present one request and hold it until taken.
	task automatic send_pair(logic [15:0] a, logic [15:0] b, logic lst);
		if (idle_on && ($urandom % 100 < 25)) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1;
		elem_a <= a;
		elem_b <= b;
		last <= lst;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_elem();
		case ($urandom % 5)
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// Drain results, let the block settle, then write the metric.
	task automatic set_metric(metric_t m);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic send_vector(int len, bit zero_b);
		for (int i = 0; i < len; i++)
			send_pair(rand_elem(), zero_b ? 16'h0000 : rand_elem(), i == len - 1);
	endtask

	initial begin
		metric_t m;
		int sent;
		int len;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = MET_EUCLID;
		in_valid = 0;
		elem_a = 0;
		elem_b = 0;
		last = 0;
		out_stall = 0;
		idle_on = 1;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes and the zero-magnitude case under every metric
		for (int k = 0; k < 4; k++) begin
			set_metric(metric_t'(k));
			send_pair(16'h8000, 16'h7fff, 0);
			send_pair(16'h7fff, 16'h8000, 1);
			send_pair(16'h0000, 16'h0000, 1);
			send_pair(16'h8000, 16'h8000, 1);
			send_pair(16'h0100, 16'hff00, 0);
			send_pair(16'h0000, 16'h0000, 1);
		end

		// more pairs than MAX_LEN, plain and cosine
		idle_on = 0;
		set_metric(MET_COSINE);
		send_vector(MAX_LEN + 6, 0);
		set_metric(MET_EUCLID);
		send_vector(MAX_LEN + 1, 0);
		idle_on = 1;

		sent = 0;
		while (sent < 650) begin
			m = metric_t'($urandom_range(0, 3));
			set_metric(m);
			// one phase runs without any idling
			idle_on = !(sent >= 300 && sent < 420);
			for (int v = 0; v < 10; v++) begin
				len = ($urandom % 8 == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
				send_vector(len, m == MET_COSINE && $urandom % 6 == 0);
				sent += len;
			end
		end

		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
